### rtl/w2dss_pkg.sv
package w2dss_pkg;

	localparam int VAL_W      = 24;
	localparam int CRD_W      = 6;
	localparam int GS_W       = 7;
	localparam int CS_W       = 16;
	localparam int OP_W       = 2;
	localparam int IN_DATA_W  = 40;
	localparam int FIFO_DEPTH = 4;

	localparam int LR_W   = VAL_W + 1;
	localparam int LAP_W  = VAL_W + 4;
	localparam int DIF_W  = VAL_W + 2;
	localparam int PROD_W = LAP_W + CS_W + 1;
	localparam int SUM_W  = VAL_W + 6;

	localparam logic [GS_W-1:0] GRID_SIZE_RST = 7'd64;
	localparam logic [CS_W-1:0] COURANT_RST   = 16'd16384;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_COMPUTE = 2'd1,
		OP_ROTATE  = 2'd2
	} op_t;

	typedef enum logic {
		CFG_GRID_SIZE  = 1'b0,
		CFG_COURANT_SQ = 1'b1
	} cfg_idx_t;

	typedef logic [1:0] bank_t;

	function automatic bank_t bank_succ(input bank_t b);
		return (b == 2'd2) ? 2'd0 : b + 2'd1;
	endfunction

endpackage

### rtl/wave_2d_stencil_step_core.sv
// Five-point finite-difference time step of the 2D wave equation.
// Input stream: tuser carries the op (load, compute, rotate); tdata carries
// col, row and the Q7.16 load value. Output stream: one transaction per
// compute, new_value in tdata and the saturation flag in tuser.
// Configuration: cfg_we/cfg_idx/cfg_wdata write grid_size (0) or
// courant_sq (1); write only while the block is idle.
// Three frames live in six single-write, dual-read memories, each frame
// split into a checkerboard pair so that a cell's four neighbors all sit in
// the other half. A compute makes two read rounds on the neighbor half, and
// the input takes no new transaction before the second round is issued;
// loads and rotates need one round. A compute passes through the pipeline
// registers, and its result is then written into the result queue.
// A rotate holds off the next transaction until all computes in flight have
// written the next frame.
// Results drain into a 4-entry queue; the input is held off when queued plus
// in-flight results would overflow it, so a stalled receiver only blocks the
// input. Reset clears control state, restores the register defaults and
// frame roles; frame contents stay undefined until loaded or computed.
module wave_2d_stencil_step_core #(
	parameter int GRID_N = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// col [5:0], row [11:6], value [35:12], zero pad [39:36]
	input  logic [w2dss_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// op [1:0]
	input  logic [w2dss_pkg::OP_W-1:0]           s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// new_value [23:0]
	output logic [w2dss_pkg::VAL_W-1:0]          m_axis_tdata,
	// saturated [0]
	output logic                                 m_axis_tuser,
	input  logic                                 cfg_we,
	input  logic                                 cfg_idx,
	input  logic [w2dss_pkg::CS_W-1:0]           cfg_wdata
);

	import w2dss_pkg::*;

	localparam int SZ_W  = ($clog2(GRID_N + 1) > GS_W) ? $clog2(GRID_N + 1) : GS_W;
	localparam int HALF  = (GRID_N + 1) / 2;
	localparam int DEPTH = GRID_N * HALF;
	localparam int AW    = $clog2(DEPTH);
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [SZ_W-1:0] N_MAX = SZ_W'(GRID_N);
	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((2 ** (VAL_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-(2 ** (VAL_W - 1)));

	function automatic logic [AW-1:0] cell_addr(input logic [CRD_W-1:0] r,
		input logic [CRD_W-1:0] c);
		return AW'(int'(r) * HALF + int'(c >> 1));
	endfunction

	logic [GS_W-1:0] grid_size_q;
	logic [CS_W-1:0] courant_q;
	bank_t           frame_select_q;
	logic            rot_hold_q;

	logic [CRD_W-1:0] col_in, row_in;
	logic signed [VAL_W-1:0] value_in;
	logic [OP_W-1:0] op_in;
	logic            p_in;
	logic [SZ_W-1:0] gs_ext, size_n, col_ext, row_ext;
	logic            in_grid, interior;
	logic [AW-1:0]   ctr_in, left_in, right_in, up_in, dn_in;
	logic            accept, acc_compute, acc_rotate, load_we;
	bank_t           cur_now;

	logic            pipe_busy;
	logic [CNT_W:0]  inflight, credit_sum;
	logic            credit_ok;

	// stage 1: second read round pending
	logic            s1_v;
	logic [AW-1:0]   up_s1, dn_s1, ctr_s1;
	logic            p_s1, int_s1, wr_s1;
	bank_t           sel_s1;
	// stage 2
	logic            s2_v;
	logic signed [LR_W-1:0]  lr_s2;
	logic signed [VAL_W-1:0] c_s2, pv_s2;
	logic [AW-1:0]   ctr_s2;
	logic            p_s2, int_s2, wr_s2;
	bank_t           sel_s2;
	// stage 3
	logic            s3_v;
	logic signed [LAP_W-1:0] lap_s3;
	logic signed [DIF_W-1:0] d_s3;
	logic [AW-1:0]   ctr_s3;
	logic            p_s3, int_s3, wr_s3;
	bank_t           sel_s3;
	// stage 4
	logic            s4_v;
	logic signed [PROD_W-1:0] prod_s4;
	logic signed [DIF_W-1:0]  d_s4;
	logic [AW-1:0]   ctr_s4;
	logic            p_s4, int_s4, wr_s4;
	bank_t           sel_s4;

	logic signed [VAL_W-1:0] rd_a [3][2];
	logic signed [VAL_W-1:0] rd_b [3][2];
	logic [AW-1:0]   rd_a_addr [2];
	logic [AW-1:0]   rd_b_addr [2];
	logic            mem_we    [3][2];
	logic [AW-1:0]   mem_waddr [3][2];
	logic [VAL_W-1:0] mem_wdata [3][2];

	bank_t           cur1, cur2, next4;
	logic signed [VAL_W-1:0] c1, pv1, l1, r1, up2, dn2;
	logic signed [LAP_W-1:0] lap2;
	logic signed [DIF_W-1:0] d2;
	logic signed [CS_W:0]    coef;
	logic signed [PROD_W-1:0] prod3;
	logic signed [SUM_W-1:0]  sum4;
	logic signed [VAL_W-1:0]  res4;
	logic            sat4, nxt_we;

	logic [VAL_W:0]  fifo_mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fifo_cnt_q;
	logic            pop;

	assign col_in   = s_axis_tdata[CRD_W-1:0];
	assign row_in   = s_axis_tdata[2*CRD_W-1:CRD_W];
	assign value_in = s_axis_tdata[2*CRD_W+VAL_W-1:2*CRD_W];
	assign op_in    = s_axis_tuser;
	assign p_in     = row_in[0] ^ col_in[0];

	always_comb begin
		gs_ext = SZ_W'(grid_size_q);
		if (gs_ext < SZ_W'(3)) begin
			size_n = SZ_W'(3);
		end else if (gs_ext > N_MAX) begin
			size_n = N_MAX;
		end else begin
			size_n = gs_ext;
		end
	end

	assign col_ext  = SZ_W'(col_in);
	assign row_ext  = SZ_W'(row_in);
	assign in_grid  = (col_ext < size_n) && (row_ext < size_n);
	assign interior = (col_in != '0) && (row_in != '0) &&
		(col_ext < size_n - SZ_W'(1)) && (row_ext < size_n - SZ_W'(1));

	assign ctr_in   = cell_addr(row_in, col_in);
	assign left_in  = cell_addr(row_in, col_in - CRD_W'(1));
	assign right_in = cell_addr(row_in, col_in + CRD_W'(1));
	assign up_in    = cell_addr(row_in - CRD_W'(1), col_in);
	assign dn_in    = cell_addr(row_in + CRD_W'(1), col_in);

	assign pipe_busy  = s2_v || s3_v || s4_v;
	assign inflight   = (CNT_W+1)'(s1_v) + (CNT_W+1)'(s2_v) + (CNT_W+1)'(s3_v)
		+ (CNT_W+1)'(s4_v);
	assign credit_sum = (CNT_W+1)'(fifo_cnt_q) + inflight;
	assign credit_ok  = credit_sum < (CNT_W+1)'(FIFO_DEPTH);

	assign s_axis_tready = !s1_v && credit_ok && !(rot_hold_q && pipe_busy);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign acc_compute   = accept && (op_in == OP_COMPUTE);
	assign acc_rotate    = accept && (op_in == OP_ROTATE);
	assign load_we       = accept && (op_in == OP_LOAD) && in_grid;
	assign cur_now       = bank_succ(frame_select_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q    <= GRID_SIZE_RST;
			courant_q      <= COURANT_RST;
			frame_select_q <= '0;
			rot_hold_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_GRID_SIZE: begin
						grid_size_q <= cfg_wdata[GS_W-1:0];
					end
					CFG_COURANT_SQ: begin
						courant_q <= cfg_wdata;
					end
					default: begin
					end
				endcase
			end
			if (acc_rotate) begin
				frame_select_q <= cur_now;
				rot_hold_q     <= 1'b1;
			end else if (!pipe_busy) begin
				rot_hold_q <= 1'b0;
			end
		end
	end

	// read addresses: first round center and left/right, second round up/down
	always_comb begin
		for (int h = 0; h < 2; h++) begin
			if (s1_v) begin
				rd_a_addr[h] = up_s1;
				rd_b_addr[h] = dn_s1;
			end else begin
				rd_a_addr[h] = (1'(h) == p_in) ? ctr_in : left_in;
				rd_b_addr[h] = right_in;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int h = 0; h < 2; h++) begin
				mem_we[k][h]    = 1'b0;
				mem_waddr[k][h] = ctr_in;
				mem_wdata[k][h] = value_in;
				if (load_we && (1'(h) == p_in) &&
					((bank_t'(k) == frame_select_q) || (bank_t'(k) == cur_now))) begin
					mem_we[k][h] = 1'b1;
				end else if (nxt_we && (1'(h) == p_s4) && (bank_t'(k) == next4)) begin
					mem_we[k][h]    = 1'b1;
					mem_waddr[k][h] = ctr_s4;
					mem_wdata[k][h] = res4;
				end
			end
		end
	end

	for (genvar gk = 0; gk < 3; gk++) begin : g_bank
		for (genvar gh = 0; gh < 2; gh++) begin : g_half
			logic [VAL_W-1:0] mem [DEPTH];
			logic [VAL_W-1:0] rd_a_q, rd_b_q;

			always_ff @(posedge clk) begin
				if (mem_we[gk][gh]) begin
					mem[mem_waddr[gk][gh]] <= mem_wdata[gk][gh];
				end
				rd_a_q <= mem[rd_a_addr[gh]];
				rd_b_q <= mem[rd_b_addr[gh]];
			end

			assign rd_a[gk][gh] = rd_a_q;
			assign rd_b[gk][gh] = rd_b_q;
		end
	end

	assign cur1  = bank_succ(sel_s1);
	assign c1    = rd_a[cur1][p_s1];
	assign pv1   = rd_a[sel_s1][p_s1];
	assign l1    = rd_a[cur1][!p_s1];
	assign r1    = rd_b[cur1][!p_s1];

	assign cur2  = bank_succ(sel_s2);
	assign up2   = rd_a[cur2][!p_s2];
	assign dn2   = rd_b[cur2][!p_s2];
	assign lap2  = LAP_W'(lr_s2) + LAP_W'(up2) + LAP_W'(dn2) - (LAP_W'(c_s2) <<< 2);
	assign d2    = DIF_W'(c_s2) + DIF_W'(c_s2) - DIF_W'(pv_s2);

	assign coef  = $signed({1'b0, courant_q});
	assign prod3 = PROD_W'(lap_s3) * PROD_W'(coef);

	// round half up: floor((p + 2^15) / 2^16) = (p >>> 16) + p[15]
	assign sum4  = SUM_W'($signed(prod_s4[PROD_W-1:16])) + SUM_W'(d_s4)
		+ SUM_W'({1'b0, prod_s4[15]});
	assign next4 = bank_succ(bank_succ(sel_s4));
	assign nxt_we = s4_v && wr_s4;

	always_comb begin
		res4 = '0;
		sat4 = 1'b0;
		if (int_s4) begin
			if (sum4 > SUM_MAX) begin
				res4 = SUM_MAX[VAL_W-1:0];
				sat4 = 1'b1;
			end else if (sum4 < SUM_MIN) begin
				res4 = SUM_MIN[VAL_W-1:0];
				sat4 = 1'b1;
			end else begin
				res4 = sum4[VAL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
			s3_v <= 1'b0;
			s4_v <= 1'b0;
		end else begin
			s1_v <= acc_compute;
			s2_v <= s1_v;
			s3_v <= s2_v;
			s4_v <= s3_v;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_compute) begin
			up_s1  <= up_in;
			dn_s1  <= dn_in;
			ctr_s1 <= ctr_in;
			p_s1   <= p_in;
			int_s1 <= interior;
			wr_s1  <= in_grid;
			sel_s1 <= frame_select_q;
		end
		lr_s2  <= LR_W'(l1) + LR_W'(r1);
		c_s2   <= c1;
		pv_s2  <= pv1;
		ctr_s2 <= ctr_s1;
		p_s2   <= p_s1;
		int_s2 <= int_s1;
		wr_s2  <= wr_s1;
		sel_s2 <= sel_s1;

		lap_s3 <= lap2;
		d_s3   <= d2;
		ctr_s3 <= ctr_s2;
		p_s3   <= p_s2;
		int_s3 <= int_s2;
		wr_s3  <= wr_s2;
		sel_s3 <= sel_s2;

		prod_s4 <= prod3;
		d_s4    <= d_s3;
		ctr_s4  <= ctr_s3;
		p_s4    <= p_s3;
		int_s4  <= int_s3;
		wr_s4   <= wr_s3;
		sel_s4  <= sel_s3;
	end

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = fifo_cnt_q != '0;
	assign m_axis_tdata  = fifo_mem[rd_ptr_q][VAL_W-1:0];
	assign m_axis_tuser  = fifo_mem[rd_ptr_q][VAL_W];

	always_ff @(posedge clk) begin
		if (s4_v) begin
			fifo_mem[wr_ptr_q] <= {sat4, res4};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (s4_v) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (s4_v && !pop) begin
				fifo_cnt_q <= fifo_cnt_q + CNT_W'(1);
			end else if (pop && !s4_v) begin
				fifo_cnt_q <= fifo_cnt_q - CNT_W'(1);
			end
		end
	end

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		credit_sum <= (CNT_W+1)'(FIFO_DEPTH))
		else $error("result queue overcommitted");

	a_two_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v |=> (s2_v && !s1_v))
		else $error("compute read rounds overlapped");

	a_same_roles: assert property (@(posedge clk) disable iff (!arst_n)
		(load_we && s4_v) |-> (sel_s4 == frame_select_q))
		else $error("load and compute write under different frame roles");

	a_rotate_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_rotate && (s2_v || s3_v)) |=> !accept)
		else $error("transaction taken before rotate drained");

endmodule

### test/wave_2d_stencil_step_checker.sv
module wave_2d_stencil_step_checker #(
	parameter int GRID_N = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	input  logic                                 s_axis_tready,
	input  logic [w2dss_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic [w2dss_pkg::OP_W-1:0]           s_axis_tuser,
	input  logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	input  logic [w2dss_pkg::VAL_W-1:0]          m_axis_tdata,
	input  logic                                 m_axis_tuser,
	input  logic                                 cfg_we,
	input  logic                                 cfg_idx,
	input  logic [w2dss_pkg::CS_W-1:0]           cfg_wdata,
	output int                                   errors,
	output int                                   outstanding,
	output int                                   results_seen,
	output int                                   saturations_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import w2dss_pkg::*;

	localparam int     NUM_CELLS = GRID_N * GRID_N;
	localparam longint DISP_HI   = 64'sd8388607;
	localparam longint DISP_LO   = -64'sd8388608;

	typedef logic signed [VAL_W-1:0] disp_t;

	typedef struct packed {
		disp_t new_value;
		logic  saturated;
	} cell_result_t;

	disp_t             frame_mem [3][NUM_CELLS];
	int                prev_bank;
	logic [GS_W-1:0]   grid_reg;
	logic [CS_W-1:0]   courant_reg;
	cell_result_t      expected_cells [$];

	function automatic int grid_in_use();
		if (grid_reg < 3)
			return 3;
		if (grid_reg > GRID_N)
			return GRID_N;
		return int'(grid_reg);
	endfunction

	function automatic cell_result_t advance_cell(int col, int row);
		int           n;
		int           at;
		int           cb;
		int           nb;
		longint       c;
		longint       lap;
		longint       term;
		longint       sum;
		cell_result_t res;
		n  = grid_in_use();
		cb = (prev_bank + 1) % 3;
		nb = (prev_bank + 2) % 3;
		res.new_value = '0;
		res.saturated = 1'b0;
		if (col != 0 && row != 0 && col < n - 1 && row < n - 1) begin
			at   = row * GRID_N + col;
			c    = longint'(frame_mem[cb][at]);
			lap  = longint'(frame_mem[cb][at - 1]) + longint'(frame_mem[cb][at + 1])
			     + longint'(frame_mem[cb][at - GRID_N]) + longint'(frame_mem[cb][at + GRID_N])
			     - 4 * c;
			term = (lap * longint'(courant_reg) + 32768) >>> 16;
			sum  = term + 2 * c - longint'(frame_mem[prev_bank][at]);
			if (sum > DISP_HI) begin
				sum = DISP_HI;
				res.saturated = 1'b1;
			end else if (sum < DISP_LO) begin
				sum = DISP_LO;
				res.saturated = 1'b1;
			end
			res.new_value = sum[VAL_W-1:0];
			frame_mem[nb][at] = res.new_value;
		end else if (col < n && row < n) begin
			frame_mem[nb][row * GRID_N + col] = '0;
		end
		return res;
	endfunction

	task automatic flag_error(string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		int           col_i;
		int           row_i;
		int           at;
		int           n;
		disp_t        v;
		if (!arst_n) begin
			prev_bank        = 0;
			grid_reg         = GRID_SIZE_RST;
			courant_reg      = COURANT_RST;
			errors           = 0;
			results_seen     = 0;
			saturations_seen = 0;
			expected_cells.delete();
			outstanding      = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_GRID_SIZE)
					grid_reg = cfg_wdata[GS_W-1:0];
				else
					courant_reg = cfg_wdata;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (m_axis_tuser === 1'b1)
					saturations_seen++;
				if (expected_cells.size() == 0) begin
					flag_error($sformatf("result %0d arrived with nothing expected",
						$signed(m_axis_tdata)));
				end else begin
					want = expected_cells.pop_front();
					if (m_axis_tdata !== want.new_value)
						flag_error($sformatf("result %0d new_value got %0d, expected %0d",
							results_seen, $signed(m_axis_tdata), want.new_value));
					if (m_axis_tuser !== want.saturated)
						flag_error($sformatf("result %0d saturated got %b, expected %b",
							results_seen, m_axis_tuser, want.saturated));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				col_i = int'(s_axis_tdata[CRD_W-1:0]);
				row_i = int'(s_axis_tdata[2*CRD_W-1:CRD_W]);
				v     = s_axis_tdata[2*CRD_W+VAL_W-1:2*CRD_W];
				n     = grid_in_use();
				case (s_axis_tuser)
					OP_LOAD: begin
						if (col_i < n && row_i < n) begin
							at = row_i * GRID_N + col_i;
							frame_mem[prev_bank][at]           = v;
							frame_mem[(prev_bank + 1) % 3][at] = v;
						end
					end
					OP_COMPUTE: expected_cells.push_back(advance_cell(col_i, row_i));
					OP_ROTATE:  prev_bank = (prev_bank + 1) % 3;
					default: ;
				endcase
			end
			outstanding = expected_cells.size();
		end
	end

endmodule

### test/tb_wave_2d_stencil_step_core.sv
module tb_wave_2d_stencil_step_core;
	timeunit 1ns;
	timeprecision 1ps;
	import w2dss_pkg::*;

	localparam int GRID_N        = 64;
	localparam int NUM_CELLS     = GRID_N * GRID_N;
	localparam int TOTAL_ITEMS   = 1250;
	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int DISP_MAX      = 8388607;
	localparam int DISP_MIN      = -8388608;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [OP_W-1:0]       s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [VAL_W-1:0]      m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_we        = 1'b0;
	logic                  cfg_idx       = CFG_GRID_SIZE;
	logic [CS_W-1:0]       cfg_wdata     = '0;

	int chk_errors;
	int chk_outstanding;
	int chk_results;
	int chk_saturations;

	bit written [3][NUM_CELLS];
	int role_base    = 0;
	int eff_n        = GRID_N;
	bit src_gaps     = 1'b0;
	bit sink_gaps    = 1'b0;
	bit hold_req     = 1'b0;
	int stall_left   = 0;
	int quiet_cycles = 0;
	int items_sent   = 0;
	int computes_sent = 0;

	wave_2d_stencil_step_core #(
		.GRID_N(GRID_N)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata)
	);

	wave_2d_stencil_step_checker #(
		.GRID_N(GRID_N)
	) u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.errors          (chk_errors),
		.outstanding     (chk_outstanding),
		.results_seen    (chk_results),
		.saturations_seen(chk_saturations)
	);

	always #4 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return int'($urandom_range(0, 16777215)) + DISP_MIN;
		if (r < 70)
			return int'($urandom_range(0, 262143)) - 131072;
		if (r < 80)
			return DISP_MAX;
		if (r < 90)
			return DISP_MIN;
		return int'($urandom_range(0, 2)) - 1;
	endfunction

	function automatic bit can_compute(int col, int row);
		int at;
		int cb;
		if (col == 0 || row == 0 || col >= eff_n - 1 || row >= eff_n - 1)
			return 1'b1;
		at = row * GRID_N + col;
		cb = (role_base + 1) % 3;
		return written[cb][at] && written[cb][at - 1] && written[cb][at + 1]
		    && written[cb][at - GRID_N] && written[cb][at + GRID_N]
		    && written[role_base][at];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (sink_gaps && $urandom_range(0, 99) < 20)
					stall_left = gap_len() + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("tb_wave_2d_stencil_step_core: errors");
				$finish;
			end
		end
	end

	task automatic program_regs(int gs, int cs);
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_GRID_SIZE;
		cfg_wdata <= gs[CS_W-1:0];
		@(posedge clk);
		cfg_idx   <= CFG_COURANT_SQ;
		cfg_wdata <= cs[CS_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		eff_n = (gs < 3) ? 3 : (gs > GRID_N) ? GRID_N : gs;
	endtask

	task automatic send_item(logic [OP_W-1:0] op, int col, int row, int value);
		int gap;
		int at;
		gap = src_gaps ? gap_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'b0, value[VAL_W-1:0], row[CRD_W-1:0], col[CRD_W-1:0]};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		at = row * GRID_N + col;
		case (op)
			OP_LOAD: begin
				if (col < eff_n && row < eff_n) begin
					written[role_base][at]           = 1'b1;
					written[(role_base + 1) % 3][at] = 1'b1;
				end
			end
			OP_COMPUTE: begin
				computes_sent++;
				if (col < eff_n && row < eff_n)
					written[(role_base + 2) % 3][at] = 1'b1;
			end
			OP_ROTATE: role_base = (role_base + 1) % 3;
			default: ;
		endcase
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (chk_outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_region(int r0, int c0, int k);
		for (int r = r0; r < r0 + k; r++)
			for (int c = c0; c < c0 + k; c++)
				send_item(OP_LOAD, c, r, pick_value());
	endtask

	task automatic sweep_region(int r0, int c0, int k);
		for (int r = r0; r < r0 + k; r++)
			for (int c = c0; c < c0 + k; c++)
				if (can_compute(c, r))
					send_item(OP_COMPUTE, c, r, pick_value());
	endtask

	task automatic noise_burst(int count);
		logic [OP_W-1:0] op;
		int              col;
		int              row;
		repeat (count) begin
			op  = OP_W'($urandom_range(0, 3));
			col = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, eff_n) % 64;
			row = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, eff_n) % 64;
			if (op == OP_COMPUTE && !can_compute(col, row))
				row = 0;
			send_item(op, col, row, pick_value());
		end
	endtask

	initial begin
		int phase;
		int gs;
		int cs;
		int k;
		int r0;
		int c0;
		int steps;
		int pick;
		phase = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest grid, largest coefficient: one interior cell driven into saturation
		program_regs(3, 65535);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				send_item(OP_LOAD, c, r, (c == 1 && r == 1) ? DISP_MIN : DISP_MAX);
		send_item(OP_LOAD, 5, 5, 12345);
		send_item(OP_UNUSED, 63, 63, DISP_MIN);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				send_item(OP_COMPUTE, c, r, 0);
		send_item(OP_COMPUTE, 63, 63, DISP_MAX);
		send_item(OP_ROTATE, 0, 0, 0);
		send_item(OP_COMPUTE, 1, 1, 0);
		settle();

		while (items_sent < TOTAL_ITEMS) begin
			phase++;
			case (phase)
				1: begin gs = 64;  cs = 0;     end
				2: begin gs = 127; cs = 65535; end
				3: begin gs = 0;   cs = 16384; end
				4: begin gs = 10;  cs = 16384; end
				default: begin
					pick = $urandom_range(0, 9);
					if (pick < 7)
						gs = $urandom_range(3, 10);
					else if (pick == 7)
						gs = $urandom_range(0, 2);
					else if (pick == 8)
						gs = 64;
					else
						gs = $urandom_range(65, 127);
					pick = $urandom_range(0, 99);
					if (pick < 15)
						cs = 0;
					else if (pick < 30)
						cs = 65535;
					else if (pick < 60)
						cs = 16384;
					else
						cs = $urandom_range(0, 65535);
				end
			endcase
			program_regs(gs, cs);
			src_gaps  = ($urandom_range(0, 3) != 0);
			sink_gaps = ($urandom_range(0, 3) != 0);

			if (phase % 4 == 3) begin
				noise_burst(40);
			end else begin
				if (eff_n <= 10) begin
					k  = eff_n;
					r0 = 0;
					c0 = 0;
				end else begin
					k = $urandom_range(4, 8);
					case ($urandom_range(0, 2))
						0: begin r0 = 0; c0 = 0; end
						1: begin r0 = eff_n - k; c0 = eff_n - k; end
						default: begin
							r0 = $urandom_range(0, eff_n - k);
							c0 = $urandom_range(0, eff_n - k);
						end
					endcase
				end
				load_region(r0, c0, k);
				steps = $urandom_range(1, 4);
				for (int s = 0; s < steps; s++) begin
					if (s == 0 && (phase == 4 || phase % 9 == 0)) begin
						src_gaps = 1'b0;
						hold_req = 1'b1;
					end
					sweep_region(r0, c0, k);
					if ($urandom_range(0, 99) < 15)
						noise_burst(3);
					send_item(OP_ROTATE, 0, 0, 0);
				end
			end
			settle();
		end

		$display("run covered %0d input transactions (%0d computes) over %0d phases",
			items_sent, computes_sent, phase);
		$display("%0d results checked, %0d of them saturated", chk_results, chk_saturations);
		if (chk_errors == 0 && chk_outstanding == 0)
			$display("tb_wave_2d_stencil_step_core: clean");
		else
			$display("tb_wave_2d_stencil_step_core: errors");
		$finish;
	end

endmodule

### files.f
rtl/w2dss_pkg.sv
rtl/wave_2d_stencil_step_core.sv
test/wave_2d_stencil_step_checker.sv
test/tb_wave_2d_stencil_step_core.sv
